FILE: hdl/kvim_pkg.sv
// shared types, constants and register indexes for the key vibrato and intensity mapper
package kvim_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SPACE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OSC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AT_SCALE   = 3'd6;

    localparam logic signed [15:0] FULL_PRESS = 16'sd4096;
    localparam logic [12:0]        FULL_INTEN = 13'd4096;
    localparam logic [15:0]        BRIGHT_MAX = 16'hFFFF;
    localparam logic [23:0]        HARM_MAX   = 24'hFFFFFF;
    localparam logic [7:0]         PEAK_MAX   = 8'd255;

    typedef enum logic [1:0] {
        CLS_OTHER    = 2'd0,
        CLS_PARTIAL  = 2'd1,
        CLS_RELEASED = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } t_event;

    typedef struct packed {
        logic        enable;
        logic [14:0] vel_thr;
        logic [15:0] peak_space;
        logic [7:0]  min_osc;
        logic [15:0] timeout;
        logic [15:0] rate;
        logic [15:0] at_scale;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        tick;
        logic               svalid;
        logic signed [15:0] pos;
        logic               vvalid;
        logic signed [15:0] vel;
        logic [1:0]         cls;
    } t_sample;

    typedef struct packed {
        logic [23:0] harm;
        logic        active;
    } t_vib_res;

endpackage

FILE: hdl/key_vibrato_and_intensity_mapper.sv
// top level of the key vibrato and intensity mapper
// Takes one key sample per item and gives one result item for each, one item per clock
// cycle sustained while the output is not stalled. An item lands in an input register,
// is evaluated there combinationally against the per-key state (vibrato peak tracker,
// note flag, previous outputs), and its result is held in an output register. o_out_valid
// rises once the item has moved from the input register into the output register. While
// enabled, the per-key state is updated in the same cycle that the item moves into the
// output register, which is what lets the next item follow directly. Input stall rises
// only while both the input and output registers hold items and the output is stalled.
module key_vibrato_and_intensity_mapper
    import kvim_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [31:0]           i_tick_time,
    input  logic                  i_sample_valid,
    input  logic signed [15:0]    i_key_position,
    input  logic                  i_velocity_valid,
    input  logic signed [15:0]    i_filtered_velocity,
    input  logic [1:0]            i_tracker_class,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [12:0]           o_intensity,
    output logic [15:0]           o_brightness,
    output logic [23:0]           o_harmonic,
    output logic                  o_vibrato_on,
    output logic [1:0]            o_note_event,
    output logic [2:0]            o_changed_mask
);

    t_cfg    r_cfg;
    t_sample r_smp;
    logic    r_in_vld;
    logic    r_out_vld;

    logic        r_note, n_note;
    logic        r_prev_known;
    logic [12:0] r_prev_inten;
    logic [15:0] r_prev_bright;
    logic [23:0] r_prev_harm;

    logic [12:0] r_intensity, n_intensity;
    logic [15:0] r_brightness, n_brightness;
    logic [23:0] r_harmonic, n_harmonic;
    logic        r_vib_on, n_vib_on;
    logic [1:0]  r_event, n_event;
    logic [2:0]  r_mask, n_mask;

    logic        w_out_free;
    logic        w_adv;
    logic        w_accept;
    logic        w_state_en;
    logic [12:0] w_inten;
    logic [15:0] w_bright;
    t_vib_res    w_vib;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_adv      = r_in_vld && w_out_free;
    assign o_in_stall = r_in_vld && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_state_en = w_adv && r_cfg.enable;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= 1'b1;
            r_cfg.vel_thr    <= 15'd1024;
            r_cfg.peak_space <= 16'd50;
            r_cfg.min_osc    <= 8'd4;
            r_cfg.timeout    <= 16'd400;
            r_cfg.rate       <= 16'd64;
            r_cfg.at_scale   <= 16'd4096;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_ENABLE:     r_cfg.enable     <= i_cfg_data[0];
                CFG_VEL_THR:    r_cfg.vel_thr    <= i_cfg_data[14:0];
                CFG_PEAK_SPACE: r_cfg.peak_space <= i_cfg_data;
                CFG_MIN_OSC:    r_cfg.min_osc    <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_cfg.timeout    <= i_cfg_data;
                CFG_RATE:       r_cfg.rate       <= i_cfg_data;
                CFG_AT_SCALE:   r_cfg.at_scale   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp.tick   <= i_tick_time;
            r_smp.svalid <= i_sample_valid;
            r_smp.pos    <= i_key_position;
            r_smp.vvalid <= i_velocity_valid;
            r_smp.vel    <= i_filtered_velocity;
            r_smp.cls    <= i_tracker_class;
        end
    end

    kvim_press u_press (
        .i_smp        (r_smp),
        .i_at_scale   (r_cfg.at_scale),
        .o_intensity  (w_inten),
        .o_brightness (w_bright)
    );

    kvim_vibrato u_vibrato (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (w_state_en),
        .i_smp       (r_smp),
        .i_cfg       (r_cfg),
        .i_prev_harm (r_prev_harm),
        .o_res       (w_vib)
    );

    // note events and change mask
    always_comb begin
        n_note  = r_note;
        n_event = EV_NONE;
        if (r_smp.svalid && (r_smp.cls == CLS_RELEASED)) begin
            if (r_note) begin
                n_event = EV_OFF;
            end
            n_note = 1'b0;
        end
        if (!n_note && (w_inten != '0)) begin
            n_event = EV_ON;
            n_note  = 1'b1;
        end

        if (!r_prev_known) begin
            n_mask = 3'b111;
        end else begin
            n_mask = {w_vib.harm != r_prev_harm, w_bright != r_prev_bright,
                      w_inten != r_prev_inten};
        end

        n_intensity  = w_inten;
        n_brightness = w_bright;
        n_harmonic   = w_vib.harm;
        n_vib_on     = w_vib.active;

        if (!r_cfg.enable) begin
            n_intensity  = '0;
            n_brightness = '0;
            n_harmonic   = '0;
            n_vib_on     = 1'b0;
            n_event      = EV_NONE;
            n_mask       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note        <= 1'b0;
            r_prev_known  <= 1'b0;
            r_prev_inten  <= '0;
            r_prev_bright <= '0;
            r_prev_harm   <= '0;
        end else if (w_state_en) begin
            r_note        <= n_note;
            r_prev_known  <= 1'b1;
            r_prev_inten  <= w_inten;
            r_prev_bright <= w_bright;
            r_prev_harm   <= w_vib.harm;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_intensity  <= n_intensity;
            r_brightness <= n_brightness;
            r_harmonic   <= n_harmonic;
            r_vib_on     <= n_vib_on;
            r_event      <= n_event;
            r_mask       <= n_mask;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_intensity    = r_intensity;
    assign o_brightness   = r_brightness;
    assign o_harmonic     = r_harmonic;
    assign o_vibrato_on   = r_vib_on;
    assign o_note_event   = r_event;
    assign o_changed_mask = r_mask;

    a_off_no_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_note_event == EV_OFF)) |-> (o_intensity == '0))
        else $error("note off with nonzero intensity");

    a_on_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_note_event == EV_ON)) |-> (o_intensity != '0))
        else $error("note on with zero intensity");

    a_bright_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_brightness != '0)) |-> (o_intensity == FULL_INTEN))
        else $error("brightness without full press");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && i_out_stall) |=> r_in_vld)
        else $error("pending item dropped while output stalled");

endmodule

FILE: hdl/kvim_press.sv
// intensity and aftertouch brightness from the key position
module kvim_press
    import kvim_pkg::*;
(
    input  t_sample     i_smp,
    input  logic [15:0] i_at_scale,
    output logic [12:0] o_intensity,
    output logic [15:0] o_brightness
);

    logic [14:0] w_diff;
    logic [30:0] w_prod;
    logic [18:0] w_shr;
    logic        w_active;

    assign w_active = i_smp.svalid && (i_smp.cls != CLS_RELEASED);
    assign w_diff   = 15'(i_smp.pos - FULL_PRESS);
    assign w_prod   = {16'b0, w_diff} * {15'b0, i_at_scale};
    assign w_shr    = w_prod[30:12];

    always_comb begin
        o_intensity  = '0;
        o_brightness = '0;
        if (w_active) begin
            if (i_smp.pos > FULL_PRESS) begin
                o_intensity  = FULL_INTEN;
                o_brightness = (|w_shr[18:16]) ? BRIGHT_MAX : w_shr[15:0];
            end else if (!i_smp.pos[15]) begin
                o_intensity = i_smp.pos[12:0];
            end
        end
    end

endmodule

FILE: hdl/kvim_vibrato.sv
// vibrato peak tracking state and harmonic accumulation
module kvim_vibrato
    import kvim_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_update,
    input  t_sample     i_smp,
    input  t_cfg        i_cfg,
    input  logic [23:0] i_prev_harm,
    output t_vib_res    o_res
);

    logic [7:0]  r_cnt, n_cnt;
    logic [31:0] r_lpt, n_lpt;
    logic        r_known, n_known;
    logic        r_act, n_act;

    logic [31:0]        w_lpt0;
    logic [31:0]        w_since;
    logic [31:0]        w_idle;
    logic               w_peak;
    logic [7:0]         w_cnt1;
    logic [31:0]        w_lpt1;
    logic               w_act1;
    logic signed [15:0] w_thr;
    logic signed [15:0] w_nthr;
    logic [15:0]        w_mag;
    logic [31:0]        w_prod;
    logic [24:0]        w_sum;
    logic [23:0]        w_harm;

    assign w_lpt0  = r_known ? r_lpt : i_smp.tick;
    assign w_since = i_smp.tick - w_lpt0;
    assign w_thr   = $signed({1'b0, i_cfg.vel_thr});
    assign w_nthr  = -w_thr;

    always_comb begin
        w_peak = 1'b0;
        if (i_smp.vvalid && (w_since > {16'b0, i_cfg.peak_space})) begin
            if (!r_cnt[0]) begin
                w_peak = i_smp.vel > w_thr;
            end else begin
                w_peak = i_smp.vel < w_nthr;
            end
        end
    end

    assign w_cnt1 = (w_peak && (r_cnt != PEAK_MAX)) ? r_cnt + 8'd1 : r_cnt;
    assign w_lpt1 = w_peak ? i_smp.tick : w_lpt0;
    assign w_act1 = r_act || (w_cnt1 >= i_cfg.min_osc);
    assign w_idle = i_smp.tick - w_lpt1;

    assign w_mag  = !i_smp.vvalid ? 16'd0 :
                    (i_smp.vel[15] ? 16'(-i_smp.vel) : i_smp.vel);
    assign w_prod = {16'b0, w_mag} * {16'b0, i_cfg.rate};
    assign w_sum  = {1'b0, i_prev_harm} + {5'b0, w_prod[31:12]};
    assign w_harm = w_sum[24] ? HARM_MAX : w_sum[23:0];

    always_comb begin
        n_cnt      = r_cnt;
        n_lpt      = r_lpt;
        n_known    = r_known;
        n_act      = r_act;
        o_res.harm = '0;
        if (i_smp.svalid) begin
            if (i_smp.cls == CLS_PARTIAL) begin
                n_cnt   = w_cnt1;
                n_lpt   = w_lpt1;
                n_known = 1'b1;
                n_act   = w_act1;
                if (w_act1) begin
                    o_res.harm = w_harm;
                    if (w_idle > {16'b0, i_cfg.timeout}) begin
                        n_act = 1'b0;
                        n_cnt = '0;
                        n_lpt = i_smp.tick;
                    end
                end
            end else begin
                n_act   = 1'b0;
                n_cnt   = '0;
                n_lpt   = i_smp.tick;
                n_known = 1'b1;
            end
        end
        o_res.active = i_smp.svalid && n_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_lpt   <= '0;
            r_known <= 1'b0;
            r_act   <= 1'b0;
        end else if (i_update) begin
            r_cnt   <= n_cnt;
            r_lpt   <= n_lpt;
            r_known <= n_known;
            r_act   <= n_act;
        end
    end

endmodule
